@@ hdl/bezier_curve_point_eval_defines.svh @@
// assertion macros used by the checker file
`ifndef BEZIER_CURVE_POINT_EVAL_DEFINES_SVH
`define BEZIER_CURVE_POINT_EVAL_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define BCPE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcpe assertion failed");

// next-cycle implication, disabled while reset is low
`define BCPE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcpe assertion failed");

`endif

@@ hdl/bcpe_pkg.sv @@
package bcpe_pkg;

    localparam int MAX_ORDER_DEF   = 8;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH     = 2;

    // widest order the binomial table covers
    localparam int ORDER_LIMIT = 16;
    localparam int ORDER_W     = 4;
    localparam int BINOM_W     = 13;
    localparam int INDEX_W     = 3;
    localparam int PARAM_W     = 16;
    localparam int MIN_ORDER   = 2;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd4;
    localparam logic [PARAM_W-1:0] T_ONE       = 16'd32768;
    localparam int                 HALF_LSB    = 16384;

    typedef enum logic [0:0] {
        CMD_WRITE = 1'b0,
        CMD_EVAL  = 1'b1
    } t_cmd;

    // classified command as it travels from front to back
    typedef struct packed {
        t_cmd               cmd;
        logic [ORDER_W-1:0] degree;
        logic [PARAM_W-1:0] tval;
        logic [PARAM_W-1:0] uval;
    } t_ctl;

    typedef logic [ORDER_LIMIT-1:0][ORDER_LIMIT-1:0][BINOM_W-1:0] t_binom_tab;

    // pascal triangle, row n holds C(n, i)
    function automatic t_binom_tab f_binom_tab();
        t_binom_tab tab;
        int         row [ORDER_LIMIT];
        tab = '0;
        for (int j = 0; j < ORDER_LIMIT; j++) begin
            row[j] = 0;
        end
        row[0] = 1;
        for (int n = 0; n < ORDER_LIMIT; n++) begin
            for (int i = n; i > 0; i--) begin
                row[i] = row[i] + row[i-1];
            end
            for (int i = 0; i < ORDER_LIMIT; i++) begin
                tab[n][i] = BINOM_W'(row[i]);
            end
        end
        return tab;
    endfunction

    localparam t_binom_tab BINOM_TAB = f_binom_tab();

endpackage

@@ hdl/bcpe_fifo.sv @@
module bcpe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push & ~o_full;
    assign rd_en   = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (wr_en) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (rd_en) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ hdl/bcpe_front.sv @@
module bcpe_front #(
    parameter int MAX_ORDER   = bcpe_pkg::MAX_ORDER_DEF,
    parameter int COORD_WIDTH = bcpe_pkg::COORD_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bcpe_pkg::ORDER_W-1:0]      i_cfg_wdata,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic                              i_command,
    input  logic [bcpe_pkg::INDEX_W-1:0]      i_point_index,
    input  logic signed [COORD_WIDTH-1:0]     i_coord_x,
    input  logic signed [COORD_WIDTH-1:0]     i_coord_y,
    input  logic signed [COORD_WIDTH-1:0]     i_coord_z,
    input  logic [bcpe_pkg::PARAM_W-1:0]      i_curve_param,
    output logic                              o_valid,
    input  logic                              i_pop,
    output bcpe_pkg::t_ctl                    o_ctl,
    output logic [$clog2(MAX_ORDER)-1:0]      o_idx,
    output logic signed [COORD_WIDTH-1:0]     o_coord_x,
    output logic signed [COORD_WIDTH-1:0]     o_coord_y,
    output logic signed [COORD_WIDTH-1:0]     o_coord_z
);
    import bcpe_pkg::*;

    localparam int IW = $clog2(MAX_ORDER);
    localparam int QW = $bits(t_ctl) + IW + 3 * COORD_WIDTH;

    logic [ORDER_W-1:0] r_order;
    t_ctl               ctl;
    logic [IW-1:0]      idx;
    logic               keep;
    logic               q_empty;
    logic [QW-1:0]      q_wdata, q_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_RESET;
        end else if (i_cfg_we) begin
            r_order <= i_cfg_wdata;
        end
    end

    always_comb begin
        int ord;
        ord = int'(r_order);
        // order is clamped here, the register keeps what was written
        if (ord < MIN_ORDER) begin
            ord = MIN_ORDER;
        end
        if (ord > MAX_ORDER) begin
            ord = MAX_ORDER;
        end
        ctl.cmd    = t_cmd'(i_command);
        ctl.degree = ORDER_W'(ord - 1);
        ctl.tval   = (i_curve_param > T_ONE) ? T_ONE : i_curve_param;
        ctl.uval   = T_ONE - ctl.tval;
        idx        = IW'(i_point_index);
        // writes beyond the table are dropped
        keep = (ctl.cmd == CMD_EVAL) || (int'(i_point_index) < MAX_ORDER);
    end

    assign q_wdata = {ctl, idx, i_coord_x, i_coord_y, i_coord_z};

    bcpe_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push & keep),
        .i_data  (q_wdata),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    assign o_valid = ~q_empty;
    assign {o_ctl, o_idx, o_coord_x, o_coord_y, o_coord_z} = q_rdata;

endmodule

@@ hdl/bcpe_back.sv @@
module bcpe_back #(
    parameter int MAX_ORDER   = bcpe_pkg::MAX_ORDER_DEF,
    parameter int COORD_WIDTH = bcpe_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_pop,
    input  bcpe_pkg::t_ctl                i_ctl,
    input  logic [$clog2(MAX_ORDER)-1:0]  i_idx,
    input  logic signed [COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [COORD_WIDTH-1:0] i_coord_y,
    input  logic signed [COORD_WIDTH-1:0] i_coord_z,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic signed [COORD_WIDTH-1:0] o_point_x,
    output logic signed [COORD_WIDTH-1:0] o_point_y,
    output logic signed [COORD_WIDTH-1:0] o_point_z,
    output logic                          o_saturated
);
    import bcpe_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int IW   = $clog2(MAX_ORDER);
    localparam int PW   = PARAM_W;
    localparam int PRW  = 2 * PW;
    localparam int BINW = $clog2(int'(BINOM_TAB[MAX_ORDER-1][(MAX_ORDER-1)/2]) + 1);
    localparam int WW   = BINW + PW;
    localparam int MW   = WW + 1 + CW;
    localparam int AW   = MW + $clog2(MAX_ORDER);
    localparam int RW   = 3 * CW + 1;

    localparam logic signed [AW-1:0] SAT_HI = {{(AW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [AW-1:0] SAT_LO = {{(AW-CW+1){1'b1}}, {(CW-1){1'b0}}};

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_POWER  = 6'b000010,
        S_TERM   = 6'b000100,
        S_WEIGHT = 6'b001000,
        S_MAC    = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state                r_state, n_state;
    logic [IW-1:0]         r_cnt, n_cnt, cnt_inc;
    logic [IW-1:0]         r_deg;
    logic [PW-1:0]         r_t, r_u, r_tp;
    logic [PW-1:0]         r_stack [MAX_ORDER];
    logic [PRW-1:0]        r_prod;
    logic [BINW-1:0]       r_binom;
    logic [WW-1:0]         r_w;
    logic signed [CW-1:0]  r_pv  [3];
    logic signed [AW-1:0]  r_acc [3];
    logic signed [CW-1:0]  r_pts [MAX_ORDER][3];

    logic [PRW-1:0]        pow_full, tp_full, term_prod;
    logic [PW-1:0]         pow_next, tp_next;
    logic [BINW+PRW-1:0]   weight_full;
    logic [WW-1:0]         w_next;
    logic signed [MW-1:0]  mac [3];
    logic signed [AW-1:0]  rnd [3];
    logic signed [CW-1:0]  res [3];
    logic                  clip;
    logic                  table_we, res_push, res_full;
    logic [RW-1:0]         res_rdata;

    assign o_pop    = (r_state == S_IDLE) && i_valid;
    assign table_we = o_pop && (i_ctl.cmd == CMD_WRITE);
    assign res_push = (r_state == S_DONE);
    assign cnt_inc  = r_cnt + 1'b1;

    // powers rounded back to q1.15, term product kept full width, weight rounded by 15 bits
    assign pow_full    = r_stack[0] * r_u;
    assign pow_next    = PW'((pow_full + PRW'(HALF_LSB)) >> 15);
    assign tp_full     = r_tp * r_t;
    assign tp_next     = PW'((tp_full + PRW'(HALF_LSB)) >> 15);
    assign term_prod   = r_tp * r_stack[0];
    assign weight_full = r_binom * r_prod;
    assign w_next      = WW'((weight_full + (BINW+PRW)'(HALF_LSB)) >> 15);

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            mac[c] = $signed({1'b0, r_w}) * r_pv[c];
        end
    end

    // round half up, then clip to the coordinate range
    always_comb begin
        clip = 1'b0;
        for (int c = 0; c < 3; c++) begin
            rnd[c] = (r_acc[c] + AW'(HALF_LSB)) >>> 15;
            if (rnd[c] > SAT_HI) begin
                res[c] = SAT_HI[CW-1:0];
                clip   = 1'b1;
            end else if (rnd[c] < SAT_LO) begin
                res[c] = SAT_LO[CW-1:0];
                clip   = 1'b1;
            end else begin
                res[c] = rnd[c][CW-1:0];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && i_ctl.cmd == CMD_EVAL) begin
                    n_state = S_POWER;
                    n_cnt   = '0;
                end
            end
            S_POWER: begin
                if (cnt_inc == r_deg) begin
                    n_state = S_TERM;
                    n_cnt   = '0;
                end else begin
                    n_cnt = cnt_inc;
                end
            end
            S_TERM:   n_state = S_WEIGHT;
            S_WEIGHT: n_state = S_MAC;
            S_MAC: begin
                if (r_cnt == r_deg) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_TERM;
                    n_cnt   = cnt_inc;
                end
            end
            S_DONE: begin
                if (!res_full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_ORDER; j++) begin
                for (int c = 0; c < 3; c++) begin
                    r_pts[j][c] <= '0;
                end
            end
        end else if (table_we) begin
            r_pts[i_idx][0] <= i_coord_x;
            r_pts[i_idx][1] <= i_coord_y;
            r_pts[i_idx][2] <= i_coord_z;
        end
    end

    // u powers are pushed onto a stack and popped in reverse for the terms
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_t        <= i_ctl.tval;
                r_u        <= i_ctl.uval;
                r_deg      <= IW'(i_ctl.degree);
                r_stack[0] <= T_ONE;
                r_tp       <= T_ONE;
                for (int c = 0; c < 3; c++) begin
                    r_acc[c] <= '0;
                end
            end
            S_POWER: begin
                r_stack[0] <= pow_next;
                for (int j = 1; j < MAX_ORDER; j++) begin
                    r_stack[j] <= r_stack[j-1];
                end
            end
            S_TERM: begin
                r_prod  <= term_prod;
                r_tp    <= tp_next;
                r_binom <= BINW'(BINOM_TAB[ORDER_W'(r_deg)][ORDER_W'(r_cnt)]);
                for (int j = 0; j < MAX_ORDER - 1; j++) begin
                    r_stack[j] <= r_stack[j+1];
                end
            end
            S_WEIGHT: begin
                r_w <= w_next;
                for (int c = 0; c < 3; c++) begin
                    r_pv[c] <= r_pts[r_cnt][c];
                end
            end
            S_MAC: begin
                for (int c = 0; c < 3; c++) begin
                    r_acc[c] <= r_acc[c] + AW'(mac[c]);
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    bcpe_fifo #(
        .WIDTH (RW),
        .DEPTH (QUEUE_DEPTH)
    ) u_result_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  ({res[0], res[1], res[2], clip}),
        .o_full  (res_full),
        .i_pop   (i_pop),
        .o_data  (res_rdata),
        .o_empty (o_empty)
    );

    assign {o_point_x, o_point_y, o_point_z, o_saturated} = res_rdata;

endmodule

@@ hdl/bezier_curve_point_eval.sv @@
// bezier curve point evaluator, bernstein form, fixed point. a write item
// (command 0) stores one control point of three signed q4.12 coordinates
// and gives no result; an evaluate item (command 1) takes t in q1.15,
// clamped to 1.0, and returns one curve point, each coordinate rounded half
// up and saturated, with o_saturated set when any coordinate was clipped.
// the order register (r_order, reset 4) picks how many control points
// take part and is clamped to 2..MAX_ORDER when used. items go through a
// short command queue into a sequencer; results leave through a result
// queue, so input and output stall independently. a write is stored while
// the sequencer is idle; an evaluate with degree n = order - 1 runs n power
// steps for 1 - t, then a multiply chain per control point (power product,
// binomial weight, multiply-accumulate), then a done step that rounds and
// queues the point, waiting while the result queue is full. the
// control-point table is zero after reset.
module bezier_curve_point_eval #(
    parameter int MAX_ORDER   = bcpe_pkg::MAX_ORDER_DEF,
    parameter int COORD_WIDTH = bcpe_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // order register write
    input  logic                          i_cfg_we,
    input  logic [bcpe_pkg::ORDER_W-1:0]  i_cfg_wdata,
    // input transfer: push while not full
    input  logic                          push,
    output logic                          full,
    input  logic                          i_command,
    input  logic [bcpe_pkg::INDEX_W-1:0]  i_point_index,
    input  logic signed [COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [COORD_WIDTH-1:0] i_coord_y,
    input  logic signed [COORD_WIDTH-1:0] i_coord_z,
    input  logic [bcpe_pkg::PARAM_W-1:0]  i_curve_param,
    // result transfer: pop while not empty
    output logic                          empty,
    input  logic                          pop,
    output logic signed [COORD_WIDTH-1:0] o_point_x,
    output logic signed [COORD_WIDTH-1:0] o_point_y,
    output logic signed [COORD_WIDTH-1:0] o_point_z,
    output logic                          o_saturated
);
    import bcpe_pkg::*;

    localparam int IW = $clog2(MAX_ORDER);

    // front to back queue head
    logic                   q_valid;
    logic                   q_pop;
    t_ctl                   q_ctl;
    logic [IW-1:0]          q_idx;
    logic signed [COORD_WIDTH-1:0] q_coord_x, q_coord_y, q_coord_z;

    // front: order register, command classification, t clamp, command queue
    bcpe_front #(
        .MAX_ORDER   (MAX_ORDER),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_push        (push),
        .o_full        (full),
        .i_command     (i_command),
        .i_point_index (i_point_index),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_curve_param (i_curve_param),
        .o_valid       (q_valid),
        .i_pop         (q_pop),
        .o_ctl         (q_ctl),
        .o_idx         (q_idx),
        .o_coord_x     (q_coord_x),
        .o_coord_y     (q_coord_y),
        .o_coord_z     (q_coord_z)
    );

    // back: control-point table, evaluation sequencer, result queue
    bcpe_back #(
        .MAX_ORDER   (MAX_ORDER),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .o_pop       (q_pop),
        .i_ctl       (q_ctl),
        .i_idx       (q_idx),
        .i_coord_x   (q_coord_x),
        .i_coord_y   (q_coord_y),
        .i_coord_z   (q_coord_z),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y),
        .o_point_z   (o_point_z),
        .o_saturated (o_saturated)
    );

endmodule

@@ hdl/bcpe_checker.sv @@
`include "bezier_curve_point_eval_defines.svh"

module bcpe_checker #(
    parameter int COORD_WIDTH = bcpe_pkg::COORD_WIDTH_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          push,
    input logic                          full,
    input logic                          i_command,
    input logic                          empty,
    input logic                          pop,
    input logic signed [COORD_WIDTH-1:0] o_point_x,
    input logic signed [COORD_WIDTH-1:0] o_point_y,
    input logic signed [COORD_WIDTH-1:0] o_point_z,
    input logic                          o_saturated
);
    localparam logic signed [COORD_WIDTH-1:0] HI = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] LO = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic [7:0]             r_open, n_open;
    logic                   eval_in, res_out;
    logic                   at_limit;
    logic [3*COORD_WIDTH:0] res_bus;

    assign eval_in = push && !full && i_command;
    assign res_out = pop && !empty;

    // some coordinate sits on a range limit
    assign at_limit = (o_point_x == HI) || (o_point_x == LO) ||
                      (o_point_y == HI) || (o_point_y == LO) ||
                      (o_point_z == HI) || (o_point_z == LO);
    assign res_bus  = {o_point_x, o_point_y, o_point_z, o_saturated};

    // evaluates taken whose results are not yet transferred
    always_comb begin
        n_open = r_open;
        if (eval_in && !res_out) begin
            n_open = r_open + 1'b1;
        end else if (res_out && !eval_in) begin
            n_open = r_open - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else begin
            r_open <= n_open;
        end
    end

    `BCPE_ASSERT_IMP(a_result_has_eval, i_clk, i_rst_n, !empty, r_open != 8'd0)
    `BCPE_ASSERT_IMP(a_sat_at_limit, i_clk, i_rst_n, !empty && o_saturated, at_limit)
    `BCPE_ASSERT_IMP(a_clear_after_reset, i_clk, i_rst_n, $past(!i_rst_n), empty && !full)
    `BCPE_ASSERT_NXT(a_result_holds, i_clk, i_rst_n, !empty && !pop, !empty && $stable(res_bus))

endmodule

bind bezier_curve_point_eval bcpe_checker #(.COORD_WIDTH(COORD_WIDTH)) u_bcpe_checker (.*);

@@ test/tb_bezier_curve_point_eval.sv @@
`default_nettype none

module tb_bezier_curve_point_eval;
    timeunit 1ns;
    timeprecision 1ps;

    import bcpe_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 10;
    localparam int NPTS           = MAX_ORDER_DEF;
    localparam int CW             = COORD_WIDTH_DEF;
    localparam int ITEMS_PER_STEP = 85;
    localparam int SETTLE_CYCLES  = 64;   // lets the longest evaluate finish, plus queueing
    localparam int HOLD_CYCLES    = 400;
    localparam int BUSY_PCT       = 22;
    localparam int WRITE_PCT      = 35;
    localparam int CALM_STEP      = 4;    // order step that runs without idling
    localparam int HOLD_STEP      = 2;    // order step with the long receiver hold-off

    localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

    // one input item as it goes over the input transfer
    typedef struct {
        t_cmd                   cmd;
        logic [INDEX_W-1:0]     slot;
        logic signed [CW-1:0]   cx;
        logic signed [CW-1:0]   cy;
        logic signed [CW-1:0]   cz;
        logic [PARAM_W-1:0]     tparam;
    } t_curve_cmd;

    // one curve point as it leaves over the result transfer
    typedef struct {
        logic signed [CW-1:0]   xyz [3];
        logic                   sat;
    } t_curve_point;

    // order settings walked through after the reset-value step; 0, 1, 9 and 15 hit the clamps
    localparam logic [ORDER_W-1:0] ORDER_PLAN [10] = '{
        4'd0, 4'd2, 4'd8, 4'd15, 4'd3, 4'd1, 4'd5, 4'd7, 4'd6, 4'd9
    };

    // clock and reset, every input known from time zero
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [ORDER_W-1:0]     i_cfg_wdata = '0;
    logic                   push = 1'b0;
    logic                   full;
    logic                   i_command = 1'b0;
    logic [INDEX_W-1:0]     i_point_index = '0;
    logic signed [CW-1:0]   i_coord_x = '0;
    logic signed [CW-1:0]   i_coord_y = '0;
    logic signed [CW-1:0]   i_coord_z = '0;
    logic [PARAM_W-1:0]     i_curve_param = '0;
    logic                   empty;
    logic                   pop = 1'b0;
    logic signed [CW-1:0]   o_point_x;
    logic signed [CW-1:0]   o_point_y;
    logic signed [CW-1:0]   o_point_z;
    logic                   o_saturated;

    // shadow of the block: control-point table and order register
    logic signed [CW-1:0]   ctrl_pts [NPTS][3];
    logic [ORDER_W-1:0]     order_reg = ORDER_RESET;

    t_curve_cmd             cmd_backlog [$];        // items waiting for the input side
    t_curve_point           curve_points_due [$];   // predicted points, oldest first
    t_curve_cmd             on_pins;                // item currently offered
    bit                     pins_taken = 1'b0;
    int                     busy_pct = BUSY_PCT;
    bit                     hold_req = 1'b0;
    int                     hold_left = 0;
    int                     mismatch_count = 0;

    always #(CLK_PERIOD/2) i_clk = ~i_clk;

    bezier_curve_point_eval u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .push          (push),
        .full          (full),
        .i_command     (i_command),
        .i_point_index (i_point_index),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_curve_param (i_curve_param),
        .empty         (empty),
        .pop           (pop),
        .o_point_x     (o_point_x),
        .o_point_y     (o_point_y),
        .o_point_z     (o_point_z),
        .o_saturated   (o_saturated)
    );

    // bernstein sum at t for the current order, q1.15 weights on q4.12 points
    function automatic t_curve_point bernstein_point(input logic [PARAM_W-1:0] tparam);
        longint       tpow [NPTS];
        longint       upow [NPTS];
        longint       coef [NPTS];
        longint       acc  [3];
        longint       tv;
        longint       uv;
        longint       wgt;
        longint       rnd;
        int           deg;
        t_curve_point pt;
        // order clamped to 2..NPTS, degree is one less
        if (order_reg < MIN_ORDER) begin
            deg = MIN_ORDER - 1;
        end else if (order_reg > NPTS) begin
            deg = NPTS - 1;
        end else begin
            deg = int'(order_reg) - 1;
        end
        // t above one is taken as one
        tv = (tparam > T_ONE) ? longint'(T_ONE) : longint'(tparam);
        uv = longint'(T_ONE) - tv;
        tpow[0] = T_ONE;
        upow[0] = T_ONE;
        for (int k = 1; k <= deg; k++) begin
            tpow[k] = (tpow[k-1] * tv + HALF_LSB) >>> 15;
            upow[k] = (upow[k-1] * uv + HALF_LSB) >>> 15;
        end
        // pascal row for the degree, built in place
        coef[0] = 1;
        for (int k = 1; k <= deg; k++) begin
            coef[k] = 1;
            for (int i = k - 1; i > 0; i--) begin
                coef[i] = coef[i] + coef[i-1];
            end
        end
        acc = '{0, 0, 0};
        for (int i = 0; i <= deg; i++) begin
            wgt = (coef[i] * tpow[i] * upow[deg-i] + HALF_LSB) >>> 15;
            for (int c = 0; c < 3; c++) begin
                acc[c] += wgt * longint'(ctrl_pts[i][c]);
            end
        end
        // round half up (arithmetic shift floors), then clip
        pt.sat = 1'b0;
        for (int c = 0; c < 3; c++) begin
            rnd = (acc[c] + HALF_LSB) >>> 15;
            if (rnd > longint'(COORD_MAX)) begin
                rnd = COORD_MAX;
                pt.sat = 1'b1;
            end else if (rnd < longint'(COORD_MIN)) begin
                rnd = COORD_MIN;
                pt.sat = 1'b1;
            end
            pt.xyz[c] = rnd[CW-1:0];
        end
        return pt;
    endfunction

    // effect of one accepted item on the shadow state and the due list
    function automatic void take_item(input t_curve_cmd it);
        if (it.cmd == CMD_WRITE) begin
            ctrl_pts[it.slot][0] = it.cx;
            ctrl_pts[it.slot][1] = it.cy;
            ctrl_pts[it.slot][2] = it.cz;
        end else begin
            curve_points_due.push_back(bernstein_point(it.tparam));
        end
    endfunction

    // coordinate with the extremes well represented
    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(19))
            0, 1:    return COORD_MAX;
            2:       return COORD_MIN;
            3:       return CW'($urandom_range(8191));
            default: return CW'($urandom());
        endcase
    endfunction

    // write item; curve_param is don't-care so it gets noise
    function automatic t_curve_cmd mk_write(input int slot, input logic signed [CW-1:0] x,
                                            input logic signed [CW-1:0] y,
                                            input logic signed [CW-1:0] z);
        t_curve_cmd it;
        it.cmd    = CMD_WRITE;
        it.slot   = INDEX_W'(slot);
        it.cx     = x;
        it.cy     = y;
        it.cz     = z;
        it.tparam = PARAM_W'($urandom());
        return it;
    endfunction

    // evaluate item; slot and coords are don't-care so they get noise
    function automatic t_curve_cmd mk_eval(input logic [PARAM_W-1:0] tparam);
        t_curve_cmd it;
        it.cmd    = CMD_EVAL;
        it.slot   = INDEX_W'($urandom());
        it.cx     = CW'($urandom());
        it.cy     = CW'($urandom());
        it.cz     = CW'($urandom());
        it.tparam = tparam;
        return it;
    endfunction

    function automatic t_curve_cmd random_item();
        logic [PARAM_W-1:0] tp;
        if ($urandom_range(99) < WRITE_PCT) begin
            return mk_write($urandom_range(NPTS - 1), rand_coord(), rand_coord(), rand_coord());
        end
        case ($urandom_range(9))
            0:       tp = '0;
            1:       tp = T_ONE;
            2:       tp = PARAM_W'($urandom_range(3));
            3:       tp = T_ONE - PARAM_W'($urandom_range(3));
            4, 5:    tp = PARAM_W'($urandom());        // often above one, clamped
            default: tp = PARAM_W'($urandom_range(T_ONE));
        endcase
        return mk_eval(tp);
    endfunction

    // input side, sample half: an item transfers when push is high and full is low
    always @(posedge i_clk) begin
        if (i_rst_n && push && !full) begin
            take_item(on_pins);
            pins_taken = 1'b1;
        end
    end

    // input side, drive half: offer the next item or idle, at the falling edge
    always @(negedge i_clk) begin
        if (!push || pins_taken) begin
            pins_taken = 1'b0;
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= busy_pct) begin
                on_pins = cmd_backlog.pop_front();
                push          <= 1'b1;
                i_command     <= on_pins.cmd;
                i_point_index <= on_pins.slot;
                i_coord_x     <= on_pins.cx;
                i_coord_y     <= on_pins.cy;
                i_coord_z     <= on_pins.cz;
                i_curve_param <= on_pins.tparam;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // result side, pop driver with its own hold-off counter
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= busy_pct);
        end
    end

    // result side, checker: each transfer against the oldest predicted point
    always @(posedge i_clk) begin
        t_curve_point want;
        logic signed [CW-1:0] got [3];
        if (i_rst_n && pop && !empty) begin
            if (curve_points_due.size() == 0) begin
                $display("%0t: result transfer with no point due, got x=%0d y=%0d z=%0d sat=%0b",
                         $realtime, o_point_x, o_point_y, o_point_z, o_saturated);
                mismatch_count++;
            end else begin
                want = curve_points_due.pop_front();
                got  = '{o_point_x, o_point_y, o_point_z};
                for (int c = 0; c < 3; c++) begin
                    if (got[c] !== want.xyz[c]) begin
                        $display("%0t: coord %0d mismatch, expected %0d actual %0d",
                                 $realtime, c, want.xyz[c], got[c]);
                        mismatch_count++;
                    end
                end
                if (o_saturated !== want.sat) begin
                    $display("%0t: saturated flag mismatch, expected %0b actual %0b",
                             $realtime, want.sat, o_saturated);
                    mismatch_count++;
                end
            end
        end
    end

    // wait for the input backlog and all due points, then let trailing writes settle
    task automatic drain();
        while (cmd_backlog.size() != 0 || push || curve_points_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // order register write, only called while the block is idle
    task automatic program_order(input logic [ORDER_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        order_reg = value;
    endtask

    // main sequence
    initial begin
        for (int i = 0; i < NPTS; i++) begin
            ctrl_pts[i] = '{0, 0, 0};
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, at the reset order of 4
        cmd_backlog.push_back(mk_eval(16'd16384));                  // table still zero
        for (int i = 0; i < 4; i++) begin
            cmd_backlog.push_back(mk_write(i, COORD_MAX, COORD_MIN, COORD_MAX));
        end
        cmd_backlog.push_back(mk_eval(16'd0));                      // t = 0 gives first point
        cmd_backlog.push_back(mk_eval(T_ONE));                      // t = 1 gives last point
        cmd_backlog.push_back(mk_eval(16'hFFFF));                   // above one, clamped
        cmd_backlog.push_back(mk_eval(16'd10923));                  // weight sum may overshoot
        cmd_backlog.push_back(mk_eval(16'd1));
        cmd_backlog.push_back(mk_eval(16'd32767));
        for (int i = 0; i < 4; i++) begin
            cmd_backlog.push_back(mk_write(i, COORD_MIN, COORD_MAX, -16'sd1));
        end
        cmd_backlog.push_back(mk_eval(16'd21845));
        cmd_backlog.push_back(mk_eval(16'd32769));                  // just above one
        cmd_backlog.push_back(mk_write(7, 16'sd1, -16'sd1, 16'sh1234));  // unused slot
        cmd_backlog.push_back(mk_write(0, 16'sd0, 16'sd0, 16'sd0));
        cmd_backlog.push_back(mk_eval(16'd16384));
        drain();

        // random, one step per order setting
        foreach (ORDER_PLAN[s]) begin
            program_order(ORDER_PLAN[s]);
            busy_pct = (s == CALM_STEP) ? 0 : BUSY_PCT;
            if (s == HOLD_STEP) begin
                // receiver stops while items keep coming, so both queues fill up
                @(posedge i_clk);
                hold_req = 1'b1;
            end
            for (int n = 0; n < ITEMS_PER_STEP; n++) begin
                cmd_backlog.push_back(random_item());
            end
            drain();
        end

        if (mismatch_count == 0 && curve_points_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog, well beyond the slowest legal run
    initial begin
        #3ms;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
